>>> sv/msort_pkg.sv
// Package for the merge sorter: payload structs, data width and the
// command/status structs between controller and datapath. No dependencies.
package msort_pkg;

  localparam int unsigned DATA_WIDTH    = 32;
  localparam int unsigned MAX_ITEMS_DEF = 64;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] element;
    logic                         last_element;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] sorted_value;
    logic                         last_out;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PASS_CHK,
    ST_RUN_START,
    ST_RD,
    ST_MRG,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_WAIT
  } state_e;

  typedef struct packed {
    logic load;        // store an incoming element
    logic sort_start;  // width = 1, source = data store
    logic pass_start;  // lo = 0
    logic run_start;   // set up a, b, k, mid, hi for the run at lo
    logic merge_step;  // move one element into the destination store
    logic run_next;    // lo += 2 * width
    logic pass_next;   // swap stores, double width
    logic out_start;   // output index = 0
    logic out_load;    // capture read data into the output register
    logic out_next;    // advance output index
  } ctrl_cmd_t;

  typedef struct packed {
    logic width_lt_n;  // another merge pass is needed
    logic run_end;     // this step writes the last element of the run
    logic lo_end;      // the next run would start at or past n
    logic out_last;    // the value being emitted is the final one
  } dp_status_t;

endpackage

>>> sv/merge_sorter.sv
// Merge sorter top level. Loads the set, then runs the merge passes
// (ceil(log2 N) passes, each a pass check and, per run, a run start and then
// a read and a merge step per value), then reads, loads and offers each value.
// One set at a time: no input is taken while a set is sorted or emitted.
// rst_ni (async, active low) clears the FSM and the fill count; the stores
// are not cleared and hold nothing that is read before it is written.
module merge_sorter #(
  parameter int unsigned MAX_ITEMS = msort_pkg::MAX_ITEMS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  msort_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output msort_pkg::out_item_t out_data_o
);
  import msort_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  msort_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.last_element),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  msort_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

>>> sv/msort_ctrl.sv
// Merge sorter controller: sequences load, merge passes and output.
// Depends on msort_pkg.
module msort_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_last_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  msort_pkg::dp_status_t  status_i,
  output msort_pkg::ctrl_cmd_t   cmd_o
);
  import msort_pkg::*;

  state_e state_q, state_d;
  logic   in_fire, out_fire;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_fire && in_last_i) state_d = ST_PASS_CHK;
      end
      ST_PASS_CHK: begin
        state_d = status_i.width_lt_n ? ST_RUN_START : ST_OUT_RD;
      end
      ST_RUN_START: state_d = ST_RD;
      ST_RD:        state_d = ST_MRG;
      ST_MRG: begin
        if (!status_i.run_end)    state_d = ST_RD;
        else if (status_i.lo_end) state_d = ST_PASS_CHK;
        else                      state_d = ST_RUN_START;
      end
      ST_OUT_RD: state_d = ST_OUT_LD;
      ST_OUT_LD: state_d = ST_OUT_WAIT;
      ST_OUT_WAIT: begin
        if (out_fire) state_d = status_i.out_last ? ST_LOAD : ST_OUT_RD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o       = 1'b1;
        cmd_o.load       = in_fire;
        cmd_o.sort_start = in_fire && in_last_i;
      end
      ST_PASS_CHK: begin
        cmd_o.pass_start = status_i.width_lt_n;
        cmd_o.out_start  = !status_i.width_lt_n;
      end
      ST_RUN_START: cmd_o.run_start = 1'b1;
      ST_RD: ;
      ST_MRG: begin
        cmd_o.merge_step = 1'b1;
        cmd_o.run_next   = status_i.run_end;
        cmd_o.pass_next  = status_i.run_end && status_i.lo_end;
      end
      ST_OUT_RD: ;
      ST_OUT_LD: cmd_o.out_load = 1'b1;
      ST_OUT_WAIT: begin
        out_valid_o    = 1'b1;
        cmd_o.out_next = out_fire;
      end
      default: ;
    endcase
  end

endmodule

>>> sv/msort_dp.sv
// Merge sorter datapath: ping-pong stores, run indices, merge compare
// and the output register. Depends on msort_pkg.
module msort_dp #(
  parameter int unsigned MAX_ITEMS = msort_pkg::MAX_ITEMS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  msort_pkg::in_item_t   in_data_i,
  input  msort_pkg::ctrl_cmd_t  cmd_i,
  output msort_pkg::dp_status_t status_o,
  output msort_pkg::out_item_t  out_data_o
);
  import msort_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  // index sums reach below 3 * MAX_ITEMS
  localparam int unsigned IW = AW + 2;

  typedef logic signed [DATA_WIDTH-1:0] word_t;

  word_t store0 [MAX_ITEMS];  // data store
  word_t store1 [MAX_ITEMS];  // scratch store
  word_t rd0a_q, rd0b_q, rd1a_q, rd1b_q;
  word_t ra, rb, wr_val;

  logic [CW-1:0] count_q, count_inc;
  logic          store_full;
  logic [IW-1:0] n_q, width_q, lo_q, mid_q, hi_q, a_q, b_q, k_q;
  logic [IW-1:0] mid_c, hi_c, lo_next, a_inc;
  logic          src_q;  // 0: source is the data store
  logic          take_a;
  out_item_t     out_q;

  assign store_full = (count_q == CW'(MAX_ITEMS));
  assign count_inc  = store_full ? count_q : count_q + 1'b1;

  assign lo_next = lo_q + (width_q << 1);
  assign mid_c   = ((lo_q + width_q) > n_q) ? n_q : lo_q + width_q;
  assign hi_c    = (lo_next > n_q) ? n_q : lo_next;
  assign a_inc   = a_q + 1'b1;

  assign ra     = src_q ? rd1a_q : rd0a_q;
  assign rb     = src_q ? rd1b_q : rd0b_q;
  assign take_a = (a_q < mid_q) && (!(b_q < hi_q) || (ra <= rb));
  assign wr_val = take_a ? ra : rb;

  assign status_o.width_lt_n = (width_q < n_q);
  assign status_o.run_end    = ((k_q + 1'b1) == hi_q);
  assign status_o.lo_end     = (lo_next >= n_q);
  assign status_o.out_last   = (a_inc == n_q);

  assign out_data_o = out_q;

  // stores: one write port each, two registered read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !store_full) begin
      store0[count_q[AW-1:0]] <= in_data_i.element;
    end else if (cmd_i.merge_step && src_q) begin
      store0[k_q[AW-1:0]] <= wr_val;
    end
    if (cmd_i.merge_step && !src_q) begin
      store1[k_q[AW-1:0]] <= wr_val;
    end
    rd0a_q <= store0[a_q[AW-1:0]];
    rd0b_q <= store0[b_q[AW-1:0]];
    rd1a_q <= store1[a_q[AW-1:0]];
    rd1b_q <= store1[b_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      src_q   <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        count_q <= in_data_i.last_element ? '0 : count_inc;
      end
      if (cmd_i.sort_start) begin
        src_q <= 1'b0;
      end else if (cmd_i.pass_next) begin
        src_q <= !src_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && in_data_i.last_element) begin
      n_q <= IW'(count_inc);
    end
    if (cmd_i.sort_start) begin
      width_q <= IW'(1);
    end else if (cmd_i.pass_next) begin
      width_q <= width_q << 1;
    end
    if (cmd_i.pass_start) begin
      lo_q <= '0;
    end else if (cmd_i.run_next) begin
      lo_q <= lo_next;
    end
    if (cmd_i.run_start) begin
      a_q   <= lo_q;
      b_q   <= mid_c;
      k_q   <= lo_q;
      mid_q <= mid_c;
      hi_q  <= hi_c;
    end else if (cmd_i.merge_step) begin
      k_q <= k_q + 1'b1;
      if (take_a) a_q <= a_inc;
      else        b_q <= b_q + 1'b1;
    end else if (cmd_i.out_start) begin
      a_q <= '0;
    end else if (cmd_i.out_next) begin
      a_q <= a_inc;
    end
    if (cmd_i.out_load) begin
      out_q.sorted_value <= ra;
      out_q.last_out     <= status_o.out_last;
    end
  end

endmodule
